// ===== src/mrh_pkg.sv =====
// shared constants, types and reset values for the modbus read-holding slave
package mrh_pkg;

  localparam int NUM_REGS    = 16;
  localparam int FRAME_BYTES = 8;
  localparam int WIN_DEPTH   = FRAME_BYTES - 1;
  localparam int CHK_BYTES   = FRAME_BYTES - 2;
  localparam int IDX_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int QTY_W       = $clog2(NUM_REGS + 1);
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int BC_W        = $clog2(CHK_BYTES);

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FC_READ   = 8'h03;
  localparam logic [7:0]  EXC_FLAG  = 8'h80;
  localparam logic [7:0]  EXC_ADDR  = 8'h02;
  localparam logic [7:0]  SLAVE_RST = 8'h01;

  typedef struct packed {
    logic init;
    logic en;
    logic din;
  } crc_ctl_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [15:0]      data;
  } reg_wr_t;

  function automatic logic [15:0] reg_reset_val(input int idx);
    reg_reset_val = 16'((idx + 1) * 100);
  endfunction

endpackage

// ===== src/mrh_intf.sv =====
// valid/ready channel interfaces for input items, result items and configuration
interface mrh_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  rx_byte;
  logic [3:0]  reg_index;
  logic [15:0] reg_value;

  modport source (output valid, func, rx_byte, reg_index, reg_value, input ready);
  modport sink (input valid, func, rx_byte, reg_index, reg_value, output ready);
endinterface

interface mrh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       is_exception;
  logic       frame_end;

  modport source (output valid, tx_byte, is_exception, frame_end, input ready);
  modport sink (input valid, tx_byte, is_exception, frame_end, output ready);
endinterface

interface mrh_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/mrh_crc.sv =====
// bit-serial modbus crc-16, one data bit per cycle while enabled, lsb first
module mrh_crc (
  input  logic               clk,
  input  logic               rst_n,
  input  mrh_pkg::crc_ctl_t  ctl,
  output logic [15:0]        crc
);
  import mrh_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic        fb;

  assign fb = crc_r[0] ^ ctl.din;

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.init) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.en) begin
      crc_nxt = (crc_r >> 1) ^ (fb ? CRC_POLY : 16'h0000);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

// ===== src/mrh_regfile.sv =====
// holding register store with per-entry reset values, one write and one read port
module mrh_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mrh_pkg::reg_wr_t          wr,
  input  logic [mrh_pkg::IDX_W-1:0] raddr,
  output logic [15:0]               rdata
);
  import mrh_pkg::*;

  logic [15:0] regs_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= reg_reset_val(i);
      end
    end else if (wr.en) begin
      regs_r[wr.addr] <= wr.data;
    end
  end

  assign rdata = regs_r[raddr];

endmodule

// ===== src/modbus_rtu_read_holding_slave_top.sv =====
// modbus rtu slave, function 03: window check, response sequencer and output register
// an item is taken only in idle; a register write or a partial-window byte leaves it in idle
// a full-window byte runs the bit-serial crc over six bytes, then a decode state
// each header or data byte of a response goes through pick, send and 8 crc bit steps, crc bytes pick and send
// the longest response, the whole bank, is 37 bytes; send waits while the output slot is full
// reset: window and fill cleared, holding regs to (i+1)*100, slave id 1, no clearing pass
module modbus_rtu_read_holding_slave_top (
  input  logic             clk,
  input  logic             rst_n,
  mrh_cfg_if.sink          cfg_ch,
  mrh_in_if.sink           in_ch,
  mrh_out_if.source        out_ch
);
  import mrh_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_DEC  = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_SEND = 3'd4;
  localparam logic [2:0] ST_FEED = 3'd5;

  localparam logic [2:0] PH_ID   = 3'd0;
  localparam logic [2:0] PH_FC   = 3'd1;
  localparam logic [2:0] PH_CNT  = 3'd2;
  localparam logic [2:0] PH_HI   = 3'd3;
  localparam logic [2:0] PH_LO   = 3'd4;
  localparam logic [2:0] PH_CRCL = 3'd5;
  localparam logic [2:0] PH_CRCH = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        ph_r, ph_nxt;
  logic [7:0]        slave_id_r;
  logic [7:0]        win_r [WIN_DEPTH];
  logic [7:0]        win_nxt [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        rxb_r, rxb_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [7:0]        id_r, id_nxt;
  logic              fexc_r, fexc_nxt;
  logic [IDX_W-1:0]  cur_idx_r, cur_idx_nxt;
  logic [QTY_W-1:0]  qleft_r, qleft_nxt;
  logic [7:0]        b_r, b_nxt;
  logic [7:0]        sh_r, sh_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        tx_r, tx_nxt;
  logic              oexc_r, oexc_nxt;
  logic              end_r, end_nxt;

  logic              in_acc;
  logic              slot_free;
  logic              match;
  logic              bad_req;
  logic [15:0]       start_w;
  logic [15:0]       qty_w;
  logic [15:0]       crc_val;
  logic [15:0]       rdata;
  crc_ctl_t          crc_ctl;
  reg_wr_t           reg_wr;

  mrh_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .crc   (crc_val)
  );

  mrh_regfile u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (reg_wr),
    .raddr (cur_idx_r),
    .rdata (rdata)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign slot_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tx_byte      = tx_r;
  assign out_ch.is_exception = oexc_r;
  assign out_ch.frame_end    = end_r;

  assign reg_wr.en   = in_acc && in_ch.func && (32'(in_ch.reg_index) < NUM_REGS);
  assign reg_wr.addr = IDX_W'(in_ch.reg_index);
  assign reg_wr.data = in_ch.reg_value;

  assign start_w = {win_r[2], win_r[3]};
  assign qty_w   = {win_r[4], win_r[5]};
  assign match   = (win_r[0] == slave_id_r) && (win_r[1] == FC_READ) &&
                   (crc_val == {rxb_r, win_r[WIN_DEPTH-1]});
  // start plus quantity past the store also covers an oversized quantity
  assign bad_req = (start_w >= 16'(NUM_REGS)) || (qty_w == 16'd0) ||
                   (({1'b0, start_w} + {1'b0, qty_w}) > 17'(NUM_REGS));

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    rxb_nxt       = rxb_r;
    bc_nxt        = bc_r;
    bit_nxt       = bit_r;
    id_nxt        = id_r;
    fexc_nxt      = fexc_r;
    cur_idx_nxt   = cur_idx_r;
    qleft_nxt     = qleft_r;
    b_nxt         = b_r;
    sh_nxt        = sh_r;
    out_valid_nxt = out_valid_r;
    tx_nxt        = tx_r;
    oexc_nxt      = oexc_r;
    end_nxt       = end_r;
    crc_ctl       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && !in_ch.func) begin
          if (fill_r != FILL_W'(WIN_DEPTH)) begin
            // oldest first once full, same as appending at the fill position
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
              win_nxt[i] = win_r[i+1];
            end
            win_nxt[WIN_DEPTH-1] = in_ch.rx_byte;
            fill_nxt = fill_r + 1'b1;
          end else begin
            rxb_nxt      = in_ch.rx_byte;
            bc_nxt       = '0;
            bit_nxt      = '0;
            crc_ctl.init = 1'b1;
            state_nxt    = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        crc_ctl.en  = 1'b1;
        crc_ctl.din = win_r[bc_r][bit_r];
        bit_nxt     = bit_r + 1'b1;
        if (bit_r == 3'd7) begin
          bc_nxt = bc_r + 1'b1;
          if (bc_r == BC_W'(CHK_BYTES - 1)) begin
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        if (match) begin
          id_nxt       = win_r[0];
          fexc_nxt     = bad_req;
          cur_idx_nxt  = IDX_W'(start_w);
          qleft_nxt    = QTY_W'(qty_w);
          crc_ctl.init = 1'b1;
          ph_nxt       = PH_ID;
          for (int i = 0; i < WIN_DEPTH; i++) begin
            win_nxt[i] = 8'h00;
          end
          fill_nxt  = '0;
          state_nxt = ST_PICK;
        end else begin
          for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          win_nxt[WIN_DEPTH-1] = rxb_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_PICK: begin
        case (ph_r)
          PH_ID:   b_nxt = id_r;
          PH_FC:   b_nxt = fexc_r ? (FC_READ | EXC_FLAG) : FC_READ;
          PH_CNT:  b_nxt = fexc_r ? EXC_ADDR : 8'({qleft_r, 1'b0});
          PH_HI:   b_nxt = rdata[15:8];
          PH_LO:   b_nxt = rdata[7:0];
          PH_CRCL: b_nxt = crc_val[7:0];
          default: b_nxt = crc_val[15:8];
        endcase
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          tx_nxt        = b_r;
          oexc_nxt      = fexc_r;
          end_nxt       = (ph_r == PH_CRCH);
          if (ph_r == PH_CRCL) begin
            ph_nxt    = PH_CRCH;
            state_nxt = ST_PICK;
          end else if (ph_r == PH_CRCH) begin
            state_nxt = ST_IDLE;
          end else begin
            sh_nxt    = b_r;
            bit_nxt   = '0;
            state_nxt = ST_FEED;
          end
        end
      end
      ST_FEED: begin
        crc_ctl.en  = 1'b1;
        crc_ctl.din = sh_r[0];
        sh_nxt      = sh_r >> 1;
        bit_nxt     = bit_r + 1'b1;
        if (bit_r == 3'd7) begin
          state_nxt = ST_PICK;
          case (ph_r)
            PH_ID:  ph_nxt = PH_FC;
            PH_FC:  ph_nxt = PH_CNT;
            PH_CNT: ph_nxt = fexc_r ? PH_CRCL : PH_HI;
            PH_HI:  ph_nxt = PH_LO;
            PH_LO: begin
              if (qleft_r == QTY_W'(1)) begin
                ph_nxt = PH_CRCL;
              end else begin
                ph_nxt      = PH_HI;
                cur_idx_nxt = cur_idx_r + 1'b1;
              end
              qleft_nxt = qleft_r - 1'b1;
            end
            default: ph_nxt = PH_CRCL;
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_ID;
      slave_id_r  <= SLAVE_RST;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= 8'h00;
      end
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        slave_id_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rxb_r     <= rxb_nxt;
    bc_r      <= bc_nxt;
    bit_r     <= bit_nxt;
    id_r      <= id_nxt;
    fexc_r    <= fexc_nxt;
    cur_idx_r <= cur_idx_nxt;
    qleft_r   <= qleft_nxt;
    b_r       <= b_nxt;
    sh_r      <= sh_nxt;
    tx_r      <= tx_nxt;
    oexc_r    <= oexc_nxt;
    end_r     <= end_nxt;
  end

  // the closing crc byte lands in the output register and the sequencer goes idle
  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND && ph_r == PH_CRCH && slot_free) |=>
      (state_r == ST_IDLE && out_valid_r && end_r))
    else $error("frame end not delivered on closing crc byte");

  // an exception frame never walks the data phases
  a_exc_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_CHK && state_r != ST_DEC && fexc_r) |->
      (ph_r != PH_HI && ph_r != PH_LO))
    else $error("exception frame entered data phase");

  // the window stays full while its crc is being checked
  a_chk_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK) |=> ($stable(fill_r) && fill_r == FILL_W'(WIN_DEPTH)))
    else $error("window changed during crc check");

  // the output register is never reloaded while a result still waits
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && state_r == ST_SEND) |=> (state_r == ST_SEND))
    else $error("result overwritten before being taken");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// testbench for the modbus read-holding slave: request frames, register writes, id changes
module tb;
  import mrh_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       is_exception;
    logic       frame_end;
  } tx_item_t;

  typedef enum logic [1:0] {ROW_FRAME, ROW_BAD_CRC, ROW_WRITE} row_kind_t;

  // for writes, start is the register index and qty the value
  typedef struct packed {
    row_kind_t         kind;
    logic [7:0]        id;
    logic [7:0]        fc;
    logic [15:0]       start;
    logic [15:0]       qty;
    logic signed [7:0] want_n;
    logic              want_exc;
  } stim_row_t;

  localparam logic signed [7:0] NO_TYPED = -8'sd1;
  localparam int NUM_ROWS = 11;

  logic clk = 1'b0;
  logic rst_n;

  mrh_cfg_if cfg_ch ();
  mrh_in_if  in_ch ();
  mrh_out_if out_ch ();

  modbus_rtu_read_holding_slave_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // slave state as seen from the serial line
  logic [7:0]  win_q [WIN_DEPTH];
  int          win_fill;
  logic [15:0] hold_regs [NUM_REGS];
  logic [7:0]  own_id;
  tx_item_t    pending_tx [$];

  int        errors = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;
  stim_row_t rows [NUM_ROWS];

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void reset_slave();
    for (int i = 0; i < WIN_DEPTH; i++)
      win_q[i] = 8'h00;
    win_fill = 0;
    for (int i = 0; i < NUM_REGS; i++)
      hold_regs[i] = 16'((i + 1) * 100);
    own_id = SLAVE_RST;
  endfunction

  function automatic int slave_reg_write(input logic [3:0] idx, input logic [15:0] val);
    if (int'(idx) < NUM_REGS)
      hold_regs[idx] = val;
    return 0;
  endfunction

  // returns the number of reply bytes queued for this serial byte
  function automatic int slave_rx_byte(input logic [7:0] rx);
    logic [7:0]  frame [FRAME_BYTES];
    logic [7:0]  body [$];
    logic [15:0] crc;
    logic        exc;
    int          start;
    int          qty;
    int          i;
    if (win_fill < WIN_DEPTH) begin
      win_q[win_fill] = rx;
      win_fill++;
      return 0;
    end
    for (i = 0; i < WIN_DEPTH; i++)
      frame[i] = win_q[i];
    frame[WIN_DEPTH] = rx;
    crc = CRC_INIT;
    for (i = 0; i < CHK_BYTES; i++)
      crc = crc_byte(crc, frame[i]);
    if (frame[0] != own_id || frame[1] != FC_READ || {frame[7], frame[6]} != crc) begin
      for (i = 0; i < WIN_DEPTH - 1; i++)
        win_q[i] = win_q[i + 1];
      win_q[WIN_DEPTH - 1] = rx;
      return 0;
    end
    for (i = 0; i < WIN_DEPTH; i++)
      win_q[i] = 8'h00;
    win_fill = 0;
    start = {frame[2], frame[3]};
    qty = {frame[4], frame[5]};
    exc = (start >= NUM_REGS || qty == 0 || start + qty > NUM_REGS);
    body.push_back(frame[0]);
    if (exc) begin
      body.push_back(FC_READ | EXC_FLAG);
      body.push_back(EXC_ADDR);
    end else begin
      body.push_back(FC_READ);
      body.push_back(8'(qty * 2));
      for (i = start; i < start + qty; i++) begin
        body.push_back(hold_regs[i][15:8]);
        body.push_back(hold_regs[i][7:0]);
      end
    end
    crc = CRC_INIT;
    foreach (body[j]) begin
      crc = crc_byte(crc, body[j]);
      pending_tx.push_back({body[j], exc, 1'b0});
    end
    pending_tx.push_back({crc[7:0], exc, 1'b0});
    pending_tx.push_back({crc[15:8], exc, 1'b1});
    return body.size() + 2;
  endfunction

  // valid stays high after acceptance unless a gap follows
  task automatic send_item(input logic func, input logic [7:0] rx, input logic [3:0] idx,
                           input logic [15:0] val, output int n_out);
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.rx_byte   <= rx;
    in_ch.reg_index <= idx;
    in_ch.reg_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    n_out = func ? slave_reg_write(idx, val) : slave_rx_byte(rx);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] fc,
                            input logic [15:0] start, input logic [15:0] qty,
                            input logic bad_crc, input int n_bytes, output int n_out);
    logic [7:0]  req [FRAME_BYTES];
    logic [15:0] crc;
    int          n;
    req[0] = id;
    req[1] = fc;
    req[2] = start[15:8];
    req[3] = start[7:0];
    req[4] = qty[15:8];
    req[5] = qty[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < CHK_BYTES; i++)
      crc = crc_byte(crc, req[i]);
    if (bad_crc)
      crc ^= 16'($urandom_range(1, 65535));
    req[6] = crc[7:0];
    req[7] = crc[15:8];
    n_out = 0;
    for (int i = 0; i < n_bytes; i++) begin
      send_item(1'b0, req[i], 4'($urandom), 16'($urandom), n);
      n_out += n;
    end
  endtask

  // sender holds off until every reply byte is back and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_tx.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slave_id(input logic [7:0] id);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= id;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    own_id = id;
  endtask

  task automatic random_traffic(input int n_items);
    int          sent;
    int          n;
    int          len;
    logic [15:0] start;
    logic [15:0] qty;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0: begin
          start = 16'($urandom_range(0, 65535));
          qty   = 16'($urandom_range(0, 65535));
        end
        1: begin
          start = 16'($urandom_range(0, NUM_REGS - 1));
          qty   = 16'h0000;
        end
        2: begin
          start = 16'($urandom_range(0, NUM_REGS - 1));
          qty   = 16'(NUM_REGS - int'(start) + $urandom_range(1, 3));
        end
        3: begin
          start = 16'(NUM_REGS + $urandom_range(0, 3));
          qty   = 16'($urandom_range(1, NUM_REGS));
        end
        default: begin
          start = 16'($urandom_range(0, NUM_REGS - 1));
          qty   = 16'($urandom_range(1, NUM_REGS - int'(start)));
        end
      endcase
      case ($urandom_range(0, 19))
        0: begin
          send_frame(own_id ^ 8'($urandom_range(1, 255)), FC_READ, start, qty, 1'b0,
                     FRAME_BYTES, n);
          sent += FRAME_BYTES;
        end
        1: begin
          send_frame(own_id, 8'($urandom_range(0, 255)), start, qty, 1'b0, FRAME_BYTES, n);
          sent += FRAME_BYTES;
        end
        2: begin
          send_frame(own_id, FC_READ, start, qty, 1'b1, FRAME_BYTES, n);
          sent += FRAME_BYTES;
        end
        3: begin
          // truncated request, leaves the window misaligned
          len = $urandom_range(1, FRAME_BYTES - 1);
          send_frame(own_id, FC_READ, start, qty, 1'b0, len, n);
          sent += len;
        end
        4, 5, 6: begin
          send_item(1'b1, 8'($urandom), 4'($urandom_range(0, 15)), 16'($urandom), n);
          sent++;
        end
        7: begin
          len = $urandom_range(1, 5);
          repeat (len) send_item(1'b0, 8'($urandom), 4'($urandom), 16'($urandom), n);
          sent += len;
        end
        default: begin
          send_frame(own_id, FC_READ, start, qty, 1'b0, FRAME_BYTES, n);
          sent += FRAME_BYTES;
        end
      endcase
      if (!calm && $urandom_range(0, 39) == 0)
        settle();
    end
  endtask

  initial begin : main_seq
    int n;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= 1'b0;
    in_ch.rx_byte   <= 8'h00;
    in_ch.reg_index <= 4'h0;
    in_ch.reg_value <= 16'h0000;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= 8'h00;
    reset_slave();
    rows = '{
      // whole bank straight after reset, longest reply
      '{ROW_FRAME,   8'd1,  FC_READ, 16'd0,     16'd16,    8'sd37,   1'b0},
      '{ROW_WRITE,   8'd0,  8'h00,   16'd15,    16'hFFFF,  8'sd0,    1'b0},
      '{ROW_WRITE,   8'd0,  8'h00,   16'd0,     16'h0000,  8'sd0,    1'b0},
      '{ROW_FRAME,   8'd1,  FC_READ, 16'd14,    16'd2,     NO_TYPED, 1'b0},
      '{ROW_FRAME,   8'd1,  FC_READ, 16'd16,    16'd1,     8'sd5,    1'b1},
      '{ROW_FRAME,   8'd1,  FC_READ, 16'd3,     16'd0,     8'sd5,    1'b1},
      '{ROW_FRAME,   8'd1,  FC_READ, 16'd15,    16'd2,     8'sd5,    1'b1},
      '{ROW_FRAME,   8'd1,  FC_READ, 16'hFFFF,  16'hFFFF,  8'sd5,    1'b1},
      // another slave, another function, corrupted check bytes
      '{ROW_FRAME,   8'hFF, FC_READ, 16'd0,     16'd1,     8'sd0,    1'b0},
      '{ROW_FRAME,   8'd1,  8'h04,   16'd0,     16'd1,     8'sd0,    1'b0},
      '{ROW_BAD_CRC, 8'd1,  FC_READ, 16'd0,     16'd1,     8'sd0,    1'b0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_WRITE)
        send_item(1'b1, 8'($urandom), rows[r].start[3:0], rows[r].qty, n);
      else
        send_frame(rows[r].id, rows[r].fc, rows[r].start, rows[r].qty,
                   rows[r].kind == ROW_BAD_CRC, FRAME_BYTES, n);
      if (rows[r].want_n != NO_TYPED &&
          (n != rows[r].want_n ||
           (n > 0 && pending_tx[$].is_exception != rows[r].want_exc))) begin
        $display("%0t: row %0d expected %0d bytes exception %b, actual %0d bytes",
                 $time, r, rows[r].want_n, rows[r].want_exc, n);
        errors++;
      end
    end
    settle();

    write_slave_id(8'd247);
    random_traffic(110);
    write_slave_id(8'd0);
    random_traffic(90);
    write_slave_id(8'd255);
    random_traffic(90);
    write_slave_id(8'($urandom_range(2, 246)));
    calm = 1'b1;
    random_traffic(90);
    settle();

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // result side: random stall bursts, none once the run is calm
  initial begin : sink_drive
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    tx_item_t want;
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      if (pending_tx.size() == 0) begin
        $display("%0t: unexpected item tx_byte %h exception %b end %b", $time,
                 out_ch.tx_byte, out_ch.is_exception, out_ch.frame_end);
        errors++;
      end else begin
        want = pending_tx.pop_front();
        if (out_ch.tx_byte !== want.tx_byte) begin
          $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, out_ch.tx_byte);
          errors++;
        end
        if (out_ch.is_exception !== want.is_exception) begin
          $display("%0t: is_exception expected %b actual %b", $time, want.is_exception,
                   out_ch.is_exception);
          errors++;
        end
        if (out_ch.frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                   out_ch.frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
